/* sv/pps_pkg.sv */
// Shared constants and controller/datapath interface types for the proximity screen.
package pps_pkg;

    localparam int COORD_W         = 28;
    localparam int IDX_OUT_W       = 6;
    localparam int SEP_W           = 29;
    localparam int THR_W           = 29;
    localparam int D2_W            = 2 * THR_W;
    localparam int SQ_W            = 2 * COORD_W;
    localparam int ROOT_STEPS      = SEP_W;
    localparam int POS_W           = 3 * COORD_W;
    localparam int S_TDATA_W       = 88;
    localparam int M_TDATA_W       = 48;
    localparam int MAX_OBJECTS_DEF = 64;

    localparam logic [THR_W-1:0] THR_RESET      = THR_W'(10240);
    localparam logic [D2_W-1:0]  LIMIT_SQ_RESET = D2_W'(64'd104857600);

    typedef struct packed {
        logic take;
        logic rd;
        logic diff;
        logic sq;
        logic sum;
        logic k_inc;
        logic sqrt_start;
        logic pend_load;
        logic pend_clr;
        logic emit;
        logic emit_last;
    } pps_cmd_t;

    typedef struct packed {
        logic drop;
        logic idx_zero;
        logic k_last;
        logic hit;
        logic root_done;
        logic pend_valid;
        logic out_free;
    } pps_status_t;

endpackage

/* sv/pps_sqrt.sv */
// Bit-serial floor square root, one result bit per cycle.
module pps_sqrt
    import pps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [D2_W-1:0]   radicand,
    output logic              done,
    output logic [SEP_W-1:0]  root
);

    localparam int REM_W = SEP_W + 2;
    localparam int CNT_W = $clog2(ROOT_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [D2_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [SEP_W-1:0]  root_reg, root_next;

    logic [REM_W+1:0]  rem_shift;
    logic [REM_W+1:0]  trial;

    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[D2_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(ROOT_STEPS - 1);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[D2_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = REM_W'(rem_shift - trial);
                root_next = {root_reg[SEP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_shift);
                root_next = {root_reg[SEP_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* sv/pps_datapath.sv */
// Position store, distance arithmetic, pending result and output register.
module pps_datapath
    import pps_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata,
    input  logic                  s_tuser,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  pps_cmd_t              cmd,
    output pps_status_t           status
);

    localparam int IDX_W = $clog2(MAX_OBJECTS);
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] n;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        n = -d;
        return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
    endfunction

    logic [POS_W-1:0]    mem [MAX_OBJECTS];
    logic [POS_W-1:0]    rd_data_reg;

    logic [D2_W-1:0]     limit_sq_reg;
    logic [D2_W-1:0]     thr_sq;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    eff_count;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [POS_W-1:0]    pos_reg;

    logic [COORD_W-1:0]  ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]     sx_reg, sy_reg, sz_reg;
    logic [D2_W-1:0]     d2_reg;

    logic                root_done;
    logic [SEP_W-1:0]    root;

    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic [SEP_W-1:0]    pend_sep_reg;

    logic                out_valid_reg, out_valid_next;
    logic [IDX_OUT_W-1:0] out_earlier_reg, out_later_reg;
    logic [SEP_W-1:0]    out_sep_reg;
    logic                out_last_reg;

    logic [IDX_W+IDX_OUT_W-1:0] pend_idx_ext, later_idx_ext;

    assign thr_sq    = cfg_wdata * cfg_wdata;
    assign eff_count = s_tuser ? '0 : count_reg;

    assign pend_idx_ext  = {{IDX_OUT_W{1'b0}}, pend_idx_reg};
    assign later_idx_ext = {{IDX_OUT_W{1'b0}}, idx_reg};

    always_comb
    begin
        count_next = count_reg;
        k_next     = k_reg;
        if (cmd.take)
        begin
            count_next = CNT_W'(eff_count + CNT_W'(1));
            k_next     = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + IDX_W'(1);
        end

        pend_valid_next = pend_valid_reg;
        if (cmd.pend_load)
            pend_valid_next = 1'b1;
        else if (cmd.pend_clr)
            pend_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_sq_reg   <= LIMIT_SQ_RESET;
            count_reg      <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_sq_reg <= thr_sq;
            count_reg      <= count_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            mem[eff_count[IDX_W-1:0]] <= s_tdata[POS_W-1:0];
        if (cmd.rd)
            rd_data_reg <= mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pos_reg <= s_tdata[POS_W-1:0];
            idx_reg <= eff_count[IDX_W-1:0];
        end
        if (cmd.diff)
        begin
            ax_reg <= abs_diff(pos_reg[COORD_W-1:0], rd_data_reg[COORD_W-1:0]);
            ay_reg <= abs_diff(pos_reg[2*COORD_W-1:COORD_W],
                               rd_data_reg[2*COORD_W-1:COORD_W]);
            az_reg <= abs_diff(pos_reg[3*COORD_W-1:2*COORD_W],
                               rd_data_reg[3*COORD_W-1:2*COORD_W]);
        end
        if (cmd.sq)
        begin
            sx_reg <= ax_reg * ax_reg;
            sy_reg <= ay_reg * ay_reg;
            sz_reg <= az_reg * az_reg;
        end
        if (cmd.sum)
            d2_reg <= {2'b00, sx_reg} + {2'b00, sy_reg} + {2'b00, sz_reg};
        if (cmd.pend_load)
        begin
            pend_idx_reg <= k_reg;
            pend_sep_reg <= root;
        end
        if (cmd.emit)
        begin
            out_earlier_reg <= pend_idx_ext[IDX_OUT_W-1:0];
            out_later_reg   <= later_idx_ext[IDX_OUT_W-1:0];
            out_sep_reg     <= pend_sep_reg;
            out_last_reg    <= cmd.emit_last;
        end
    end

    pps_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (d2_reg),
        .done     (root_done),
        .root     (root)
    );

    assign status.drop       = (eff_count == CNT_W'(MAX_OBJECTS));
    assign status.idx_zero   = (idx_reg == '0);
    assign status.k_last     = (k_reg == idx_reg - IDX_W'(1));
    assign status.hit        = (d2_reg < limit_sq_reg);
    assign status.root_done  = root_done;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*IDX_OUT_W - SEP_W){1'b0}},
                       out_sep_reg, out_later_reg, out_earlier_reg};

endmodule

/* sv/pps_ctrl.sv */
// Sequencer that walks earlier positions, runs the root unit and orders results.
module pps_ctrl
    import pps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  pps_status_t  status,
    output pps_cmd_t     cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_START = 10'b00_0000_0010,
        S_READ  = 10'b00_0000_0100,
        S_DIFF  = 10'b00_0000_1000,
        S_SQ    = 10'b00_0001_0000,
        S_SUM   = 10'b00_0010_0000,
        S_TEST  = 10'b00_0100_0000,
        S_ROOT  = 10'b00_1000_0000,
        S_PUSH  = 10'b01_0000_0000,
        S_FLUSH = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && !status.drop)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = status.idx_zero ? S_IDLE : S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (status.hit)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_ROOT;
                end
                else if (status.k_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_ROOT:
            begin
                if (status.root_done)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                // older pending pair goes out before the new one takes its place
                if (!status.pend_valid || status.out_free)
                begin
                    cmd.emit      = status.pend_valid;
                    cmd.pend_load = 1'b1;
                    if (status.k_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.pend_clr  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/pairwise_proximity_screen.sv */
// Sequencing: each earlier object costs five sequencer steps (read, diff, square, sum,
// test) and each close pair a 29-step bit-serial square root; an output stall holds the
// sequencer until the pending pair can go out.
// Throughput: one item at a time; the next is accepted once the last result is registered.
// Reset: sequencer idle, frame count zero, threshold back to 10240, output empty;
// stored positions stay undefined until written.
module pairwise_proximity_screen
    import pps_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata,      // close-approach limit
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,        // x_position, y_position, z_position
    input  logic                  s_tuser,        // frame_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,        // earlier_index, later_index, separation
    output logic                  m_tlast         // last_of_run
);

    pps_cmd_t    cmd;
    pps_status_t status;

    pps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pps_datapath #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for pairwise_proximity_screen: predicted close pairs vs. output stream.
module tb
    import pps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_DEPTH    = MAX_OBJECTS_DEF;
    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct {
        logic [IDX_OUT_W-1:0] earlier;
        logic [IDX_OUT_W-1:0] later;
        logic [SEP_W-1:0]     sep;
        logic                 last;
    } close_pair_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [THR_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;     // x_position, y_position, z_position
    logic                 s_tuser   = 1'b0;   // frame_start
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // earlier_index, later_index, separation
    logic                 m_tlast;            // last_of_run

    coord_t            pos_x [FRAME_DEPTH];
    coord_t            pos_y [FRAME_DEPTH];
    coord_t            pos_z [FRAME_DEPTH];
    int unsigned       frame_count     = 0;
    logic [THR_W-1:0]  threshold_model = THR_RESET;
    close_pair_t       expected_pairs [$];
    int                error_count     = 0;

    int burst_left   = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    int rx_left      = 0;
    bit rx_state     = 1'b0;
    int stall_cycles = 0;

    pairwise_proximity_screen #(
        .MAX_OBJECTS (FRAME_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [SEP_W-1:0] floor_root(logic [63:0] value);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = SEP_W; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value)
                root = trial;
        end
        return root[SEP_W-1:0];
    endfunction

    // Store the position and queue one close pair per earlier object under the limit.
    function automatic void screen_position(logic frame_start, coord_t x, coord_t y, coord_t z);
        longint      dx;
        longint      dy;
        longint      dz;
        longint      d2;
        longint      limit_sq;
        int unsigned idx;
        int unsigned k;
        close_pair_t pending;
        bit          have_pending;
        if (frame_start)
            frame_count = 0;
        if (frame_count >= FRAME_DEPTH)
            return;
        idx = frame_count;
        pos_x[idx] = x;
        pos_y[idx] = y;
        pos_z[idx] = z;
        frame_count = idx + 1;
        limit_sq = longint'(threshold_model) * longint'(threshold_model);
        have_pending = 1'b0;
        for (k = 0; k < idx; k++)
        begin
            dx = longint'(x) - longint'(pos_x[k]);
            dy = longint'(y) - longint'(pos_y[k]);
            dz = longint'(z) - longint'(pos_z[k]);
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 < limit_sq)
            begin
                if (have_pending)
                    expected_pairs.insert(expected_pairs.size(), pending);
                pending.earlier = IDX_OUT_W'(k);
                pending.later   = IDX_OUT_W'(idx);
                pending.sep     = floor_root(d2);
                pending.last    = 1'b0;
                have_pending    = 1'b1;
            end
        end
        if (have_pending)
        begin
            pending.last = 1'b1;
            expected_pairs.insert(expected_pairs.size(), pending);
        end
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t near_coord(coord_t center, int spread);
        return center + coord_t'($urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic send_position(logic frame_start, coord_t x, coord_t y, coord_t z);
        int gap;
        gap = 0;
        if (!tx_steady)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {{(S_TDATA_W - 3 * COORD_W){1'b0}}, z, y, x};
        s_tuser  <= frame_start;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        screen_position(frame_start, x, y, z);
    endtask

    // Hold the sender until every queued pair is out, then let a trailing item finish.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        drain_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        threshold_model = value;
    endtask

    task automatic test_default_threshold();
        send_position(1'b1, coord_t'(0), coord_t'(0), coord_t'(0));
        send_position(1'b0, coord_t'(10239), coord_t'(0), coord_t'(0));
        send_position(1'b0, coord_t'(10240), coord_t'(0), coord_t'(0));
        send_position(1'b0, coord_t'(0), coord_t'(-10241), coord_t'(0));
        send_position(1'b0, coord_t'(6000), coord_t'(-6000), coord_t'(5000));
    endtask

    task automatic test_threshold_edges();
        coord_t p;
        p = any_coord();
        write_threshold('0);
        send_position(1'b1, p, p, p);
        send_position(1'b0, p, p, p);
        write_threshold(THR_W'(1));
        send_position(1'b1, p, p, p);
        send_position(1'b0, p, p, p);
        send_position(1'b0, p + coord_t'(1), p, p);
    endtask

    task automatic test_coordinate_extremes();
        write_threshold(THR_MAX);
        send_position(1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
        send_position(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_position(1'b0, COORD_MAX, COORD_MIN, COORD_MAX);
        send_position(1'b0, COORD_MIN, COORD_MAX, COORD_MIN);
        send_position(1'b0, coord_t'(0), coord_t'(0), coord_t'(0));
        send_position(1'b0, coord_t'(-1), coord_t'(-1), coord_t'(-1));
        send_position(1'b0, coord_t'(28'h5555555), coord_t'(28'hAAAAAAA), coord_t'(28'h5555555));
        // frame restart in the middle of a frame
        send_position(1'b1, COORD_MAX, coord_t'(0), COORD_MIN);
        send_position(1'b0, COORD_MIN, coord_t'(0), COORD_MAX);
    endtask

    // Fill a frame, get a full run of pairs on the last slot, then overflow it.
    task automatic test_frame_capacity();
        coord_t cx;
        coord_t cy;
        coord_t cz;
        int     n;
        cx = any_coord();
        cy = any_coord();
        cz = any_coord();
        write_threshold('0);
        send_position(1'b1, cx, cy, cz);
        for (n = 1; n < FRAME_DEPTH - 1; n++)
            send_position(1'b0, near_coord(cx, 4096), near_coord(cy, 4096), near_coord(cz, 4096));
        write_threshold(THR_MAX);
        send_position(1'b0, near_coord(cx, 4096), near_coord(cy, 4096), near_coord(cz, 4096));
        send_position(1'b0, any_coord(), any_coord(), any_coord());
        send_position(1'b0, any_coord(), any_coord(), any_coord());
        send_position(1'b1, any_coord(), any_coord(), any_coord());
        send_position(1'b0, any_coord(), any_coord(), any_coord());
    endtask

    task automatic test_random_frames(int total);
        int               sent;
        int               phase;
        int               n;
        int               frame_left;
        int               spread;
        coord_t           cx;
        coord_t           cy;
        coord_t           cz;
        logic [THR_W-1:0] thr;
        logic             fs;
        sent  = 0;
        phase = 0;
        while (sent < total)
        begin
            case (phase % 4)
                0:       thr = THR_W'($urandom_range(1, 4096));
                1:       thr = THR_W'($urandom_range(4097, 1 << 22));
                2:       thr = THR_W'($urandom);
                default: thr = THR_MAX;
            endcase
            write_threshold(thr);
            tx_steady  = (phase % 3 == 2);
            rx_steady  = (phase % 3 == 1);
            spread     = (thr > THR_W'(1 << 26)) ? (1 << 26) : int'(thr);
            frame_left = 0;
            for (n = 0; n < 42 && sent < total; n++)
            begin
                if (n == 21)
                    drain_results();
                if (frame_left == 0)
                begin
                    frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24)
                                                             : $urandom_range(2, 8);
                    cx = any_coord();
                    cy = any_coord();
                    cz = any_coord();
                    fs = 1'b1;
                end
                else
                    fs = ($urandom_range(0, 15) == 0);
                frame_left--;
                if ($urandom_range(0, 6) == 0)
                    send_position(fs, any_coord(), any_coord(), any_coord());
                else
                    send_position(fs, near_coord(cx, spread), near_coord(cy, spread),
                                  near_coord(cz, spread));
                sent++;
            end
            phase++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_threshold();
        test_threshold_edges();
        test_coordinate_extremes();
        test_frame_capacity();
        test_random_frames(125);
        drain_results();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin : check_output
        close_pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pairs.size() == 0)
            begin
                error_count++;
                $error("unexpected item: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (m_tdata[IDX_OUT_W-1:0] !== want.earlier)
                begin
                    error_count++;
                    $error("earlier_index: expected %0d, actual %0d",
                           want.earlier, m_tdata[IDX_OUT_W-1:0]);
                end
                if (m_tdata[2*IDX_OUT_W-1:IDX_OUT_W] !== want.later)
                begin
                    error_count++;
                    $error("later_index: expected %0d, actual %0d",
                           want.later, m_tdata[2*IDX_OUT_W-1:IDX_OUT_W]);
                end
                if (m_tdata[2*IDX_OUT_W+SEP_W-1:2*IDX_OUT_W] !== want.sep)
                begin
                    error_count++;
                    $error("separation: expected %0d, actual %0d",
                           want.sep, m_tdata[2*IDX_OUT_W+SEP_W-1:2*IDX_OUT_W]);
                end
                if (m_tlast !== want.last)
                begin
                    error_count++;
                    $error("last_of_run: expected %0b, actual %0b", want.last, m_tlast);
                end
            end
        end
        if (rx_left == 0)
        begin
            rx_state = rx_steady || ($urandom_range(0, 3) != 0);
            rx_left  = rx_state ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        rx_left--;
        m_tready <= rx_state;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
